@@ src/slpq_pkg.sv @@
package slpq_pkg;

   // default depth of the list
   localparam int SLPQ_CAPACITY = 64;

   localparam int VALUE_W     = 32;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int POSITION_W  = 6;
   localparam int REMOVED_W   = 7;
   localparam int COUNT_OUT_W = 7;

   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = MODE_W;

   localparam int RSP_FIELDS_W = POSITION_W + REMOVED_W + 3 * VALUE_W + COUNT_OUT_W + 1;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;
   localparam int RSP_TUSER_W  = STATUS_W;

   typedef enum logic [MODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_POP    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic               ins_en;   // open a slot at the insert point, shift right
      logic               del_en;   // close a slot, shift left
      logic               del_all;  // shift left the whole row (pop)
      logic [VALUE_W-1:0] value;    // search key / insert data
   } cell_ctl_type;

endpackage

@@ src/slpq_cell.sv @@
module slpq_cell (
   input  logic                         clock,
   input  logic                         valid,
   input  slpq_pkg::cell_ctl_type       ctl,
   input  logic [slpq_pkg::VALUE_W-1:0] left_entry,
   input  logic [slpq_pkg::VALUE_W-1:0] right_entry,
   input  logic                         left_gt,
   output logic [slpq_pkg::VALUE_W-1:0] entry,
   output logic                         gt,
   output logic                         eq
);
   import slpq_pkg::*;

   logic [VALUE_W-1:0] entry_ff;
   logic [VALUE_W-1:0] entry_in;
   logic               ge;

   // gt: key sorts before this entry (or the cell is empty); monotone along the row
   always_comb begin
      gt = !valid || ($signed(ctl.value) < $signed(entry_ff));
      ge = !($signed(entry_ff) < $signed(ctl.value));
      eq = valid && (entry_ff == ctl.value);
      entry_in = entry_ff;
      if (ctl.ins_en && gt) begin
         entry_in = left_gt ? left_entry : ctl.value;
      end else if (ctl.del_en && (ctl.del_all || ge)) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ src/sorted_list_priority_queue.sv @@
// Flow: a req word is accepted in S_IDLE into the value/mode registers, the cell row
//    updates in S_EXEC, and the report goes through the pend stage into the rsp register.
//    No new word is accepted until S_EXEC is left; S_EXEC waits while a report is pending,
//    and remove of all equal copies stays in S_EXEC, deleting one copy per cycle.
// Reset: synchronous, active high; clears the entry count, the FSM and both
//    response stages. Cell contents are not reset; the count marks them valid.
module sorted_list_priority_queue #(
   parameter int CAPACITY = slpq_pkg::SLPQ_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   // req
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [slpq_pkg::REQ_TDATA_W-1:0] req_tdata,  // [31:0] value
   input  logic [slpq_pkg::REQ_TUSER_W-1:0] req_tuser,  // [1:0] mode
   // rsp
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [5:0] position, [12:6] removed_count, [44:13] popped_value,
   // [76:45] min_value, [108:77] max_value, [115:109] entry_count,
   // [116] is_empty, [119:117] zero
   output logic [slpq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [slpq_pkg::RSP_TUSER_W-1:0] rsp_tuser   // [1:0] status
);
   import slpq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,  // waiting for a req word
      S_EXEC = 2'b10   // driving the cell row
   } state_type;

   // control
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   removed_ff, removed_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload
   op_type                  mode_ff;
   logic [VALUE_W-1:0]      value_ff;
   status_type              pend_status_ff, pend_status_in;
   logic [POSITION_W-1:0]   pend_pos_ff, pend_pos_in;
   logic [REMOVED_W-1:0]    pend_removed_ff, pend_removed_in;
   logic [VALUE_W-1:0]      pend_popped_ff, pend_popped_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff;
   logic [RSP_TUSER_W-1:0]  rsp_user_ff;

   // cell row
   cell_ctl_type            ctl;
   logic [VALUE_W-1:0]      entry_vec [CAPACITY];
   logic [CAPACITY-1:0]     valid_vec, gt_vec, eq_vec, last_vec;
   logic [CAPACITY-1:0]     bnd_gt_vec, bnd_eq_vec;

   logic                    req_fire, drain, any_eq;
   logic [IDX_W-1:0]        ins_idx, hit_idx;
   logic [VALUE_W-1:0]      max_raw, min_word, max_word;
   logic                    empty;

   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   //--------------------------------------------------------------------------
   // Row of cells: each holds one list slot, shifts toward a neighbor
   //--------------------------------------------------------------------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] left_entry, right_entry;
      logic               left_gt;

      if (i == 0) begin : g_head
         assign left_entry = value_ff;
         assign left_gt    = 1'b0;
      end else begin : g_body
         assign left_entry = entry_vec[i-1];
         assign left_gt    = gt_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry  = entry_vec[i];
         assign last_vec[i]  = valid_vec[i];
      end else begin : g_mid
         assign right_entry  = entry_vec[i+1];
         assign last_vec[i]  = valid_vec[i] && !valid_vec[i+1];
      end

      assign valid_vec[i] = (count_ff > CNT_W'(i));

      slpq_cell u_cell (
         .clock       (clock),
         .valid       (valid_vec[i]),
         .ctl         (ctl),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .left_gt     (left_gt),
         .entry       (entry_vec[i]),
         .gt          (gt_vec[i]),
         .eq          (eq_vec[i])
      );
   end

   // first-hit markers; at most one bit set because the list is kept sorted
   assign bnd_gt_vec = gt_vec & ~{gt_vec[CAPACITY-2:0], 1'b0};
   assign bnd_eq_vec = eq_vec & ~{eq_vec[CAPACITY-2:0], 1'b0};
   assign any_eq     = |eq_vec;

   // index encode of the markers, and the tail entry for the max
   always_comb begin
      ins_idx = '0;
      hit_idx = '0;
      max_raw = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         ins_idx |= bnd_gt_vec[i] ? IDX_W'(i) : '0;
         hit_idx |= bnd_eq_vec[i] ? IDX_W'(i) : '0;
         max_raw |= entry_vec[i] & {VALUE_W{last_vec[i]}};
      end
   end

   assign empty    = (count_ff == '0);
   assign min_word = empty ? '1 : entry_vec[0];
   assign max_word = empty ? '1 : max_raw;

   //--------------------------------------------------------------------------
   // Sequencer
   //--------------------------------------------------------------------------
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      removed_in      = removed_ff;
      pend_valid_in   = pend_valid_ff;
      pend_status_in  = pend_status_ff;
      pend_pos_in     = pend_pos_ff;
      pend_removed_in = pend_removed_ff;
      pend_popped_in  = pend_popped_ff;
      ctl             = '{ins_en: 1'b0, del_en: 1'b0, del_all: 1'b0, value: value_ff};

      // pend stage moves into the rsp register
      drain = pend_valid_ff && (!rsp_valid_ff || rsp_tready);
      if (drain) begin
         pend_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               removed_in = '0;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            // row only moves once the previous report has been sampled
            if (!pend_valid_ff) begin
               pend_status_in  = ST_OK;
               pend_pos_in     = '0;
               pend_removed_in = '0;
               pend_popped_in  = '0;
               pend_valid_in   = 1'b1;
               state_in        = S_IDLE;
               case (mode_ff)
                  OP_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        pend_status_in = ST_FULL;
                     end else begin
                        ctl.ins_en  = 1'b1;
                        count_in    = count_ff + 1'b1;
                        pend_pos_in = POSITION_W'(ins_idx);
                     end
                  end
                  OP_REMOVE: begin
                     if (any_eq) begin
                        // one copy per cycle; report waits for the last one
                        ctl.del_en    = 1'b1;
                        count_in      = count_ff - 1'b1;
                        removed_in    = removed_ff + 1'b1;
                        pend_valid_in = 1'b0;
                        state_in      = S_EXEC;
                     end else begin
                        pend_status_in  = (removed_ff == '0) ? ST_NOT_FOUND : ST_OK;
                        pend_removed_in = REMOVED_W'(removed_ff);
                     end
                  end
                  OP_SEARCH: begin
                     if (any_eq) begin
                        pend_pos_in = POSITION_W'(hit_idx);
                     end else begin
                        pend_status_in = ST_NOT_FOUND;
                     end
                  end
                  OP_POP: begin
                     if (empty) begin
                        pend_status_in = ST_EMPTY;
                     end else begin
                        ctl.del_en     = 1'b1;
                        ctl.del_all    = 1'b1;
                        count_in       = count_ff - 1'b1;
                        pend_popped_in = entry_vec[0];
                     end
                  end
                  default: begin
                     pend_status_in = ST_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (drain) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         removed_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         removed_ff    <= removed_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff  <= op_type'(req_tuser[MODE_W-1:0]);
         value_ff <= req_tdata[VALUE_W-1:0];
      end
      pend_status_ff  <= pend_status_in;
      pend_pos_ff     <= pend_pos_in;
      pend_removed_ff <= pend_removed_in;
      pend_popped_ff  <= pend_popped_in;
      // min/max/count are read from the row after its update settled
      if (drain) begin
         rsp_user_ff <= pend_status_ff;
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, empty, COUNT_OUT_W'(count_ff), max_word,
                         min_word, pend_popped_ff, pend_removed_ff, pend_pos_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   //--------------------------------------------------------------------------
   // Checks
   //--------------------------------------------------------------------------
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_sorted_gt: assert property (@(posedge clock) disable iff (reset)
      $onehot0(bnd_gt_vec))
      else $error("insert point not unique, row out of order");

   a_sorted_eq: assert property (@(posedge clock) disable iff (reset)
      $onehot0(bnd_eq_vec))
      else $error("equal run not contiguous");

   a_hold_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) && pend_valid_ff |=> $stable(count_ff))
      else $error("row changed while a report was pending");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_EXEC))
      else $error("accepted word not executed");

endmodule

@@ tb/pq_reply_checker.sv @@
`timescale 1ns / 100ps

module pq_reply_checker #(
   parameter int CAPACITY = slpq_pkg::SLPQ_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [slpq_pkg::REQ_TDATA_W-1:0] req_tdata,   // [31:0] value
   input  logic [slpq_pkg::REQ_TUSER_W-1:0] req_tuser,   // [1:0] mode
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [5:0] position, [12:6] removed_count, [44:13] popped_value,
   // [76:45] min_value, [108:77] max_value, [115:109] entry_count,
   // [116] is_empty, [119:117] zero
   input  logic [slpq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [slpq_pkg::RSP_TUSER_W-1:0] rsp_tuser,   // [1:0] status
   output int                               mismatches,
   output int                               outstanding,
   output int                               checked
);
   import slpq_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [5:0]  position;
      logic [6:0]  removed;
      logic [31:0] popped;
      logic [31:0] min_value;
      logic [31:0] max_value;
      logic [6:0]  count;
      logic        empty;
   } reply_type;

   // shadow of the stored list, ascending
   logic signed [31:0] list_copy[$];
   // replies owed by the block, oldest first
   reply_type          due_replies[$];
   reply_type          want;
   reply_type          got;

   task automatic apply_list_op(input op_type op, input logic signed [31:0] value,
                                output reply_type r);
      int n;
      int slot;
      int hits;
      bit found;
      begin
         r = '0;
         r.status = ST_OK;
         n = list_copy.size();
         case (op)
            OP_INSERT: begin
               if (n >= CAPACITY) begin
                  r.status = ST_FULL;
               end else begin
                  // lands after any equal values
                  slot = n;
                  found = 1'b0;
                  for (int i = 0; i < n; i++) begin
                     if (!found && value < list_copy[i]) begin
                        slot = i;
                        found = 1'b1;
                     end
                  end
                  list_copy.insert(slot, value);
                  r.position = slot[5:0];
               end
            end
            OP_REMOVE: begin
               hits = 0;
               for (int i = n - 1; i >= 0; i--) begin
                  if (list_copy[i] == value) begin
                     list_copy.delete(i);
                     hits++;
                  end
               end
               r.removed = hits[6:0];
               if (hits == 0) r.status = ST_NOT_FOUND;
            end
            OP_SEARCH: begin
               r.status = ST_NOT_FOUND;
               found = 1'b0;
               for (int i = 0; i < n; i++) begin
                  if (!found && list_copy[i] == value) begin
                     found = 1'b1;
                     r.status = ST_OK;
                     r.position = i[5:0];
                  end
               end
            end
            default: begin
               if (n == 0) r.status = ST_EMPTY;
               else r.popped = list_copy.pop_front();
            end
         endcase
         n = list_copy.size();
         r.count = n[6:0];
         r.empty = (n == 0);
         // empty list reads back all ones for min and max
         r.min_value = (n == 0) ? '1 : list_copy[0];
         r.max_value = (n == 0) ? '1 : list_copy[n-1];
      end
   endtask

   task automatic compare_field(input string what, input logic [31:0] expected,
                                input logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, what, expected, actual);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         list_copy.delete();
         due_replies.delete();
         mismatches = 0;
         checked = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status    = status_type'(rsp_tuser);
            got.position  = rsp_tdata[5:0];
            got.removed   = rsp_tdata[12:6];
            got.popped    = rsp_tdata[44:13];
            got.min_value = rsp_tdata[76:45];
            got.max_value = rsp_tdata[108:77];
            got.count     = rsp_tdata[115:109];
            got.empty     = rsp_tdata[116];
            if (due_replies.size() == 0) begin
               $display("%0t: reply with none owed, expected none actual tuser %h tdata %h",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = due_replies.pop_front();
               compare_field("status", 32'(want.status), 32'(got.status));
               compare_field("position", 32'(want.position), 32'(got.position));
               compare_field("removed_count", 32'(want.removed), 32'(got.removed));
               compare_field("popped_value", want.popped, got.popped);
               compare_field("min_value", want.min_value, got.min_value);
               compare_field("max_value", want.max_value, got.max_value);
               compare_field("entry_count", 32'(want.count), 32'(got.count));
               compare_field("is_empty", 32'(want.empty), 32'(got.empty));
               compare_field("pad", '0, 32'(rsp_tdata[RSP_TDATA_W-1:RSP_FIELDS_W]));
               checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            apply_list_op(op_type'(req_tuser), req_tdata, want);
            due_replies.push_back(want);
         end
      end
      outstanding = due_replies.size();
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import slpq_pkg::*;

   // random part stops after this many request words beyond the directed ones
   localparam int WORD_TARGET  = 1000;
   // watchdog bound, set above the worst legal run of gaps, full removes and stalls
   localparam int CYCLE_LIMIT  = 400000;
   // wind-down wait, sized for the remove of a full list of copies
   localparam int DRAIN_CYCLES = SLPQ_CAPACITY + 16;

   localparam logic [31:0] INT_MIN = 32'h8000_0000;
   localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

   // traffic shapes for the random part
   localparam int PH_FILL  = 0;   // insert heavy, climbs toward capacity
   localparam int PH_DRAIN = 1;   // pop and remove heavy, hits empty
   localparam int PH_MIXED = 2;   // all ops evenly
   localparam int PH_FLOOD = 3;   // empty it, stack one value past full, remove it

   // where operand values come from
   localparam int POOL_TINY   = 0;   // three values, lots of duplicates
   localparam int POOL_NARROW = 1;   // -8..8
   localparam int POOL_WIDE   = 2;   // any 32-bit value
   localparam int POOL_EDGE   = 3;   // extremes and neighbors of zero

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;    // [31:0] value
   logic [REQ_TUSER_W-1:0] req_tuser;    // [1:0] mode
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // [5:0] position, [12:6] removed_count, [44:13] popped_value,
   // [76:45] min_value, [108:77] max_value, [115:109] entry_count,
   // [116] is_empty, [119:117] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;    // [1:0] status

   int          mismatches;
   int          outstanding;
   int          checked;
   int          cycles = 0;
   int          words;
   int          op_sent[4];
   bit          calm;                // when set neither side idles
   int          pool;
   logic [31:0] tiny_set[3];
   logic [31:0] recent_inserts[16];  // operands for search/remove that hit
   int          recent_head;
   int          recent_fill;

   sorted_list_priority_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   pq_reply_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d replies owed", $time, cycles, outstanding);
         $display("status: fail");
         $finish;
      end
   end

   // Drives one request word: optional gap with valid low, then holds valid until
   // the block takes it. Entered and left at a falling edge.
   task automatic send_word(input op_type op, input logic [31:0] value);
      int gap;
      begin
         gap = calm ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tuser  <= op;
         req_tdata  <= value;
         do @(posedge clock); while (!req_tready);
         @(negedge clock);
         op_sent[op]++;
         words++;
         if (op == OP_INSERT) begin
            recent_inserts[recent_head] = value;
            recent_head = (recent_head + 1) % 16;
            if (recent_fill < 16) recent_fill++;
         end
      end
   endtask

   function automatic op_type pick_op(input int kind);
      int r;
      begin
         r = $urandom_range(0, 99);
         case (kind)
            PH_FILL:  pick_op = (r < 70) ? OP_INSERT : (r < 80) ? OP_SEARCH :
                                (r < 85) ? OP_REMOVE : OP_POP;
            PH_DRAIN: pick_op = (r < 15) ? OP_INSERT : (r < 40) ? OP_REMOVE :
                                (r < 85) ? OP_POP : OP_SEARCH;
            default:  pick_op = op_type'(r % 4);
         endcase
      end
   endfunction

   function automatic logic [31:0] pick_value(input op_type op);
      begin
         // pop ignores the operand: keep it noisy
         if (op == OP_POP) begin
            pick_value = $urandom;
         end else if (op != OP_INSERT && recent_fill > 0 && $urandom_range(0, 1) == 1) begin
            pick_value = recent_inserts[$urandom_range(0, recent_fill - 1)];
         end else begin
            case (pool)
               POOL_TINY:   pick_value = tiny_set[$urandom_range(0, 2)];
               POOL_NARROW: pick_value = $urandom_range(0, 16) - 8;
               POOL_WIDE:   pick_value = $urandom;
               default: begin
                  case ($urandom_range(0, 5))
                     0: pick_value = INT_MIN;
                     1: pick_value = INT_MAX;
                     2: pick_value = INT_MIN + 1;
                     3: pick_value = INT_MAX - 1;
                     4: pick_value = '1;
                     default: pick_value = $urandom_range(0, 1);
                  endcase
               end
            endcase
         end
      end
   endfunction

   // Result side: per reply, a random stall with tready low, then tready high
   // until a reply goes through.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin
      int kind;
      int len;
      logic [31:0] v;
      op_type op;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_INSERT;
      words       = 0;
      calm        = 1'b0;
      pool        = POOL_NARROW;
      recent_head = 0;
      recent_fill = 0;
      foreach (op_sent[i]) op_sent[i] = 0;
      foreach (tiny_set[i]) tiny_set[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed: empty-list rejections, extremes, duplicates, ordering ----
      send_word(OP_POP, 32'h1234_5678);      // pop on empty is rejected
      send_word(OP_SEARCH, '0);              // search on empty misses
      send_word(OP_REMOVE, '0);              // remove on empty misses
      send_word(OP_INSERT, '0);
      send_word(OP_INSERT, INT_MAX);
      send_word(OP_INSERT, INT_MIN);
      send_word(OP_INSERT, '1);
      send_word(OP_INSERT, '0);              // duplicate goes after its twin
      send_word(OP_INSERT, 32'd1);
      send_word(OP_SEARCH, '0);              // first copy of a duplicate
      send_word(OP_SEARCH, INT_MAX);         // last slot
      send_word(OP_SEARCH, 32'd7);           // miss in a non-empty list
      send_word(OP_REMOVE, '0);              // takes both copies
      send_word(OP_REMOVE, '0);              // already gone
      send_word(OP_POP, '1);                 // yields the most negative value
      send_word(OP_REMOVE, INT_MAX);
      send_word(OP_SEARCH, '1);
      send_word(OP_POP, '0);
      send_word(OP_POP, INT_MIN);            // list goes empty here
      send_word(OP_POP, INT_MAX);            // and this one is rejected
      send_word(OP_INSERT, 32'h5555_5555);
      send_word(OP_INSERT, 32'haaaa_aaaa);
      send_word(OP_SEARCH, 32'haaaa_aaaa);
      send_word(OP_REMOVE, 32'h5555_5555);

      // hold off until the block has answered everything
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);

      // ---- random phases ----
      while (words < WORD_TARGET + 24) begin
         kind = $urandom_range(0, 3);
         pool = $urandom_range(0, 3);
         calm = ($urandom_range(0, 3) == 0);
         foreach (tiny_set[i]) tiny_set[i] = $urandom;
         if (kind == PH_FLOOD) begin
            // empty the list so that one value can fill every slot, overflow,
            // then be removed all at once
            repeat (SLPQ_CAPACITY) send_word(OP_POP, $urandom);
            v = pick_value(OP_INSERT);
            repeat (SLPQ_CAPACITY + $urandom_range(1, 4)) send_word(OP_INSERT, v);
            send_word(OP_SEARCH, v);
            send_word(OP_REMOVE, v);
         end else begin
            len = $urandom_range(20, 120);
            for (int k = 0; k < len; k++) begin
               op = pick_op(kind);
               send_word(op, pick_value(op));
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            while (outstanding != 0) @(negedge clock);
         end
      end
      req_tvalid <= 1'b0;

      // ---- wind down ----
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d request words: %0d insert, %0d remove, %0d search, %0d pop",
               words, op_sent[OP_INSERT], op_sent[OP_REMOVE], op_sent[OP_SEARCH],
               op_sent[OP_POP]);
      $display("fill, drain, flood and mixed phases; %0d replies checked field by field",
               checked);
      if (mismatches == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ sorted_list_priority_queue.f @@
src/slpq_pkg.sv
src/slpq_cell.sv
src/sorted_list_priority_queue.sv
tb/pq_reply_checker.sv
tb/tb.sv
